// File: hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the sorted set table
// Key type, operation codes, control state and the per-cell control bundle.
// ----------------------------------------------------------------------------
package sst_pkg;

	// key width and default capacity
	localparam int KEY_W           = 32;
	localparam int DEF_MAX_ENTRIES = 256;
	localparam int KIND_W          = 2;
	localparam int COUNT_OUT_W     = 9;
	localparam int IN_DATA_W       = 40;
	localparam int OUT_DATA_W      = 16;

	typedef logic signed [KEY_W-1:0] key_t;

	// operation codes carried in the kind field
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	// control state
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_APPLY = 1'b1
	} state_t;

	// control broadcast to every cell
	typedef struct packed {
		logic cmp; // latch compare flags against the incoming key
		logic ins; // open a gap at the insert position and write the key
		logic rem; // close the gap at the matching position
	} cell_ctl_t;

endpackage

// File: hdl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted key chain
// Holds one key, compares it with the incoming key and shifts to or from
// its neighbours when a key is inserted or removed.
// ----------------------------------------------------------------------------
module sst_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sst_pkg::cell_ctl_t ctl,
	input  sst_pkg::key_t     cmp_key,   // key of the incoming transaction
	input  sst_pkg::key_t     new_key,   // registered key for the update
	input  logic              valid,     // slot lies below the entry count
	input  sst_pkg::key_t     left_key,
	input  logic              left_lt,   // left neighbour holds a smaller key
	input  sst_pkg::key_t     right_key,
	output sst_pkg::key_t     key_q,
	output logic              lt_q,
	output logic              eq_q
);
	import sst_pkg::*;

	logic at_pos;
	logic above;

	// position of this slot relative to the first key not below the new one
	assign at_pos = left_lt && !lt_q;
	assign above  = !left_lt;

	// compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= valid && (key_q < cmp_key);
			eq_q <= valid && (key_q == cmp_key);
		end
	end

	// key shift and write
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				key_q <= new_key;
			end else if (above) begin
				key_q <= left_key;
			end
		end else if (ctl.rem) begin
			if (at_pos || above) begin
				key_q <= right_key;
			end
		end
	end

endmodule

// File: hdl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table: ordered set of distinct signed keys
// A chain of key cells with a small controller for insert, remove and test.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one operation per transaction: kind (insert, remove or
//   membership test) and a signed 32-bit key. m_axis returns one result per
//   operation: ok and the entry count after the operation.
//   Every cell compares its key with the incoming key at the accepting edge;
//   on the next edge the cells from the key's position upward shift in
//   parallel (up for an insert, down for a remove) and the result is
//   written to the output register, valid from the edge after the
//   accepting edge.
//   The block takes no new operation while the cell chain is updated for
//   the last one; it takes the next operation while the result is being
//   taken on m_axis.
//   If the receiver stalls, the result stays in the output register and no
//   further operation is accepted until it has been taken.
//   Reset clears the entry count and the handshake state; the key cells are
//   not cleared, as only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_set_table #(
	parameter int MAX_ENTRIES = sst_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [1:0] kind, [33:2] key, [39:34] zero
	input  logic [sst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] ok, [9:1] count, [15:10] zero
	output logic [sst_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import sst_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [KIND_W-1:0] kind_q;
	key_t            key_q;
	logic            out_valid_q;
	logic            ok_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic            accept;
	logic            found;
	logic            do_ins;
	logic            do_rem;
	logic            ok_d;
	cell_ctl_t       ctl;
	key_t            in_key;

	key_t            keys [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] lts;
	logic [MAX_ENTRIES-1:0] eqs;

	assign in_key = key_t'(s_axis_tdata[KIND_W +: KEY_W]);
	assign accept = s_axis_tvalid && s_axis_tready;

	// key found when the matching slot raised its flag
	assign found  = |eqs;
	assign do_ins = (kind_q == KIND_INSERT) && !found
		&& (count_q < CW'(MAX_ENTRIES));
	assign do_rem = (kind_q == KIND_REMOVE) && found;

	// result flag per operation
	always_comb begin
		unique case (kind_q)
			KIND_INSERT: ok_d = do_ins;
			KIND_REMOVE: ok_d = do_rem;
			KIND_TEST:   ok_d = found;
			default:     ok_d = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and cell control
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ctl           = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = !out_valid_q || m_axis_tready;
				ctl.cmp       = accept;
				if (accept) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctl.ins = do_ins;
				ctl.rem = do_rem;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// captured operation
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_axis_tdata[KIND_W-1:0];
			key_q  <= in_key;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.rem) begin
			count_q <= count_q - CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_APPLY) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			ok_q <= ok_d;
			if (do_ins) begin
				out_count_q <= COUNT_OUT_W'(count_q + CW'(1));
			end else if (do_rem) begin
				out_count_q <= COUNT_OUT_W'(count_q - CW'(1));
			end else begin
				out_count_q <= COUNT_OUT_W'(count_q);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_OUT_W - 1){1'b0}}, out_count_q, ok_q};

	// chain of key cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		key_t left_key;
		key_t right_key;
		logic left_lt;

		if (i == 0) begin : g_first
			assign left_key = key_q;
			assign left_lt  = 1'b1;
		end else begin : g_mid
			assign left_key = keys[i-1];
			assign left_lt  = lts[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign right_key = keys[i];
		end else begin : g_inner
			assign right_key = keys[i+1];
		end

		sst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_key   (in_key),
			.new_key   (key_q),
			.valid     (CW'(i) < count_q),
			.left_key  (left_key),
			.left_lt   (left_lt),
			.right_key (right_key),
			.key_q     (keys[i]),
			.lt_q      (lts[i]),
			.eq_q      (eqs[i])
		);
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_APPLY))
		else $error("accepted transaction not applied");

	a_apply_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> m_axis_tvalid)
		else $error("applied transaction gave no result");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_APPLY) |=> $stable(count_q))
		else $error("entry count changed outside update cycle");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eqs))
		else $error("more than one slot matches the key");

endmodule

// File: test/sorted_set_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_set_table_tb: self-checking bench for the sorted set table
// A short table of directed operations runs first. Phases of random
// operations follow, steered to fill the store to capacity and drain it
// again. Both stream sides idle at random. Every result is compared with an
// in-bench model of the ordered key set.
// ----------------------------------------------------------------------------
module sorted_set_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int SET_DEPTH = DEF_MAX_ENTRIES;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT = 22;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam key_t KEY_MIN = key_t'(32'h8000_0000);
	localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);
	localparam key_t KEY_NEG1 = key_t'(32'hffff_ffff);

	// operation mix of a random phase
	typedef enum logic [1:0] {
		MIX_BALANCED = 2'd0,
		MIX_GROW     = 2'd1,
		MIX_SHRINK   = 2'd2
	} op_mix_t;

	typedef struct {
		logic                   ok;
		logic [COUNT_OUT_W-1:0] count;
	} set_result_t;

	typedef struct {
		logic [KIND_W-1:0]      kind;
		key_t                   key;
		bit                     typed;
		logic                   ok;
		logic [COUNT_OUT_W-1:0] count;
	} op_row_t;

	typedef struct {
		op_mix_t mix;
		int      n_ops;
		int      idle_pct;
	} phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [1:0] kind, [33:2] key, [39:34] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [0] ok, [9:1] count, [15:10] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// model of the ordered key set and the results still owed by the block
	key_t        stored_keys[$];
	set_result_t pending_results[$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	int          idle_pct = IDLE_PCT;

	// directed operations: empty store, extremes, duplicates, unused kind
	op_row_t directed_ops [23] = '{
		'{KIND_TEST,   32'sd0,               1'b1, 1'b0, 9'd0},
		'{KIND_REMOVE, 32'sd5,               1'b1, 1'b0, 9'd0},
		'{KIND_UNUSED, 32'sd0,               1'b1, 1'b0, 9'd0},
		'{KIND_INSERT, KEY_MIN,              1'b1, 1'b1, 9'd1},
		'{KIND_INSERT, KEY_MAX,              1'b1, 1'b1, 9'd2},
		'{KIND_INSERT, KEY_MIN,              1'b1, 1'b0, 9'd2},
		'{KIND_TEST,   KEY_MAX,              1'b1, 1'b1, 9'd2},
		'{KIND_INSERT, 32'sd0,               1'b1, 1'b1, 9'd3},
		'{KIND_INSERT, KEY_NEG1,             1'b1, 1'b1, 9'd4},
		'{KIND_INSERT, 32'sd1,               1'b1, 1'b1, 9'd5},
		'{KIND_TEST,   KEY_NEG1,             1'b1, 1'b1, 9'd5},
		'{KIND_TEST,   32'sd2,               1'b1, 1'b0, 9'd5},
		'{KIND_UNUSED, KEY_MAX,              1'b1, 1'b0, 9'd5},
		'{KIND_REMOVE, 32'sd0,               1'b1, 1'b1, 9'd4},
		'{KIND_REMOVE, 32'sd0,               1'b1, 1'b0, 9'd4},
		'{KIND_REMOVE, KEY_MIN,              1'b1, 1'b1, 9'd3},
		'{KIND_REMOVE, KEY_MAX,              1'b1, 1'b1, 9'd2},
		'{KIND_TEST,   KEY_MIN,              1'b1, 1'b0, 9'd2},
		'{KIND_INSERT, key_t'(32'haaaa_aaaa), 1'b0, 1'b0, 9'd0},
		'{KIND_INSERT, key_t'(32'h5555_5555), 1'b0, 1'b0, 9'd0},
		'{KIND_UNUSED, key_t'(32'haaaa_aaaa), 1'b0, 1'b0, 9'd0},
		'{KIND_REMOVE, KEY_NEG1,             1'b0, 1'b0, 9'd0},
		'{KIND_TEST,   key_t'(32'h5555_5555), 1'b0, 1'b0, 9'd0}
	};

	// random phases: a balanced start, fill to capacity, hover at full, drain,
	// a balanced phase, then a burst with no idling on either side
	phase_t random_phases [6] = '{
		'{MIX_BALANCED, 150, IDLE_PCT},
		'{MIX_GROW,     450, IDLE_PCT},
		'{MIX_BALANCED, 250, IDLE_PCT},
		'{MIX_SHRINK,   650, IDLE_PCT},
		'{MIX_BALANCED, 150, IDLE_PCT},
		'{MIX_GROW,     230, 0}
	};

	sorted_set_table #(
		.MAX_ENTRIES(SET_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apply one operation to the key set model and return the result
	function automatic set_result_t apply_set_op(logic [KIND_W-1:0] kind, key_t key);
		int          pos;
		bit          hit;
		set_result_t res;
		pos = 0;
		while (pos < stored_keys.size() && stored_keys[pos] < key)
			pos++;
		hit = (pos < stored_keys.size()) && (stored_keys[pos] == key);
		res.ok = 1'b0;
		case (kind)
			KIND_INSERT: begin
				if (!hit && stored_keys.size() < SET_DEPTH) begin
					stored_keys.insert(pos, key);
					res.ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (hit) begin
					stored_keys.delete(pos);
					res.ok = 1'b1;
				end
			end
			KIND_TEST: res.ok = hit;
			default: res.ok = 1'b0;
		endcase
		res.count = COUNT_OUT_W'(stored_keys.size());
		return res;
	endfunction

	// random key: often one already stored, else dense small values,
	// extremes or anything at all
	function automatic key_t pick_key(int stored_pct);
		int r;
		r = $urandom_range(0, 99);
		if (stored_keys.size() != 0 && r < stored_pct)
			return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		r = $urandom_range(0, 99);
		if (r < 35)
			return key_t'($urandom_range(0, 63)) - 32'sd32;
		if (r < 45) begin
			case ($urandom_range(0, 3))
				0: return KEY_MIN;
				1: return KEY_MIN + 32'sd1;
				2: return KEY_MAX - 32'sd1;
				default: return KEY_MAX;
			endcase
		end
		return key_t'($urandom);
	endfunction

	// pick kind and key of one random operation
	task automatic pick_op(input op_mix_t mix, output logic [KIND_W-1:0] kind,
			output key_t key);
		int r;
		int ins_pct;
		int rem_pct;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_GROW: begin
				ins_pct = 78;
				rem_pct = 10;
			end
			MIX_SHRINK: begin
				ins_pct = 13;
				rem_pct = 70;
			end
			default: begin
				ins_pct = 38;
				rem_pct = 32;
			end
		endcase
		if (r < 3)
			kind = KIND_UNUSED;
		else if (r < 3 + ins_pct)
			kind = KIND_INSERT;
		else if (r < 3 + ins_pct + rem_pct)
			kind = KIND_REMOVE;
		else
			kind = KIND_TEST;
		key = pick_key(kind == KIND_INSERT ? 10 : 70);
	endtask

	// drive one transaction on s_axis, entered and left at a falling edge;
	// tvalid is only lowered when a gap follows
	task automatic issue_op(input logic [KIND_W-1:0] kind, input key_t key,
			input bit typed, input set_result_t typed_res);
		set_result_t res;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - KEY_W - KIND_W){1'b0}}, key, kind};
		do
			@(posedge clk);
		while (!s_axis_tready);
		res = apply_set_op(kind, key);
		pending_results.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// receiver: random back-pressure on m_axis
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		set_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: ok %0d count %0d",
					m_axis_tdata[0], m_axis_tdata[COUNT_OUT_W:1]);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata[0] !== exp_res.ok) begin
					$error("ok: expected %0d, got %0d", exp_res.ok, m_axis_tdata[0]);
					error_count++;
				end
				if (m_axis_tdata[COUNT_OUT_W:1] !== exp_res.count) begin
					$error("count: expected %0d, got %0d", exp_res.count,
						m_axis_tdata[COUNT_OUT_W:1]);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [KIND_W-1:0] kind;
		key_t              key;
		set_result_t       typed_res;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_ops[i]) begin
			typed_res.ok    = directed_ops[i].ok;
			typed_res.count = directed_ops[i].count;
			issue_op(directed_ops[i].kind, directed_ops[i].key,
				directed_ops[i].typed, typed_res);
		end

		// random phases
		typed_res.ok    = 1'b0;
		typed_res.count = '0;
		foreach (random_phases[p]) begin
			idle_pct = random_phases[p].idle_pct;
			for (int n = 0; n < random_phases[p].n_ops; n++) begin
				pick_op(random_phases[p].mix, kind, key);
				issue_op(kind, key, 1'b0, typed_res);
			end
		end
		s_axis_tvalid <= 1'b0;
		idle_pct = IDLE_PCT;

		// wait for the owed results, then let the pipeline settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hdl/sst_pkg.sv
hdl/sst_cell.sv
hdl/sorted_set_table.sv
test/sorted_set_table_tb.sv
